// ----- rtl/slum_pkg.sv -----
package slum_pkg;

    // Largest list depth that the command fields are sized for.
    localparam int MAX_DEPTH = 32;
    localparam int LIST_DEPTH = 16;
    localparam int PTR_W = $clog2(MAX_DEPTH);
    localparam int CNT_W = $clog2(MAX_DEPTH + 1);
    localparam int VAL_W = 32;

    localparam int CMDQ_DEPTH = 2;
    localparam int RESQ_DEPTH = 2;

    localparam logic [1:0] ACT_LOAD_A = 2'd0;
    localparam logic [1:0] ACT_LOAD_B = 2'd1;
    localparam logic [1:0] ACT_MERGE = 2'd2;

    typedef struct packed {
        logic [1:0] action;
        logic signed [VAL_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] union_value;
        logic last;
        logic empty_res;
        logic overflowed;
    } result_t;

    typedef enum logic [1:0] {
        CMD_LOAD_A,
        CMD_LOAD_B,
        CMD_MERGE
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t op;
        logic [PTR_W-1:0] addr;
        logic signed [VAL_W-1:0] value;
        logic [CNT_W-1:0] cnt_a;
        logic [CNT_W-1:0] cnt_b;
        logic ovf;
    } cmd_t;

endpackage

// ----- rtl/slum_fifo.sv -----
module slum_fifo
    import slum_pkg::*;
#(
    parameter type T = logic,
    parameter int DEPTH_Q = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  T     wdata,
    input  logic pop,
    output logic empty,
    output T     rdata
);

    localparam int PW = (DEPTH_Q > 1) ? $clog2(DEPTH_Q) : 1;
    localparam int QW = $clog2(DEPTH_Q + 1);

    T store [DEPTH_Q];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [QW-1:0] count_reg;
    logic do_push;
    logic do_pop;

    assign full = (count_reg == QW'(DEPTH_Q));
    assign empty = (count_reg == '0);
    assign rdata = store[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH_Q - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH_Q - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + QW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - QW'(1);
            end
        end
    end

endmodule

// ----- rtl/slum_front.sv -----
module slum_front
    import slum_pkg::*;
#(
    parameter int DEPTH = LIST_DEPTH
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    output logic  full,
    input  item_t item,
    output logic  cmd_push,
    input  logic  cmd_full,
    output cmd_t  cmd_data
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] cnt_a_reg;
    logic [CW-1:0] cnt_a_next;
    logic [CW-1:0] cnt_b_reg;
    logic [CW-1:0] cnt_b_next;
    logic ovf_reg;
    logic ovf_next;
    logic accept;

    assign full = cmd_full;
    assign accept = push && !cmd_full;

    // Counts and the overflow flag live here, so the back end only ever sees
    // loads that fit and merges that carry their own lengths.
    always_comb
    begin
        cnt_a_next = cnt_a_reg;
        cnt_b_next = cnt_b_reg;
        ovf_next = ovf_reg;
        cmd_push = 1'b0;
        cmd_data.op = CMD_MERGE;
        cmd_data.addr = '0;
        cmd_data.value = item.value;
        cmd_data.cnt_a = CNT_W'(cnt_a_reg);
        cmd_data.cnt_b = CNT_W'(cnt_b_reg);
        cmd_data.ovf = ovf_reg;
        if (accept)
        begin
            unique case (item.action)
                ACT_LOAD_A:
                begin
                    if (cnt_a_reg < CW'(DEPTH))
                    begin
                        cmd_push = 1'b1;
                        cmd_data.op = CMD_LOAD_A;
                        cmd_data.addr = PTR_W'(cnt_a_reg);
                        cnt_a_next = cnt_a_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                ACT_LOAD_B:
                begin
                    if (cnt_b_reg < CW'(DEPTH))
                    begin
                        cmd_push = 1'b1;
                        cmd_data.op = CMD_LOAD_B;
                        cmd_data.addr = PTR_W'(cnt_b_reg);
                        cnt_b_next = cnt_b_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                ACT_MERGE:
                begin
                    cmd_push = 1'b1;
                    cmd_data.op = CMD_MERGE;
                    cnt_a_next = '0;
                    cnt_b_next = '0;
                    ovf_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_a_reg <= '0;
            cnt_b_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            cnt_a_reg <= cnt_a_next;
            cnt_b_reg <= cnt_b_next;
            ovf_reg <= ovf_next;
        end
    end

`ifndef SYNTH
    a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_a_reg <= CW'(DEPTH)) && (cnt_b_reg <= CW'(DEPTH)))
        else $error("list count beyond depth");

    a_merge_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.action == ACT_MERGE)
        |=> (cnt_a_reg == '0 && cnt_b_reg == '0 && !ovf_reg))
        else $error("merge did not clear counts and overflow");
`endif

endmodule

// ----- rtl/slum_back.sv -----
module slum_back
    import slum_pkg::*;
#(
    parameter int DEPTH = LIST_DEPTH
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_empty,
    input  cmd_t    q_data,
    output logic    q_pop,
    output logic    out_push,
    input  logic    out_full,
    output result_t out_data
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EMPTY,
        ST_FETCH,
        ST_EVAL,
        ST_FLUSH
    } state_t;

    logic signed [VAL_W-1:0] mem_a [DEPTH];
    logic signed [VAL_W-1:0] mem_b [DEPTH];
    logic signed [VAL_W-1:0] rd_a_reg;
    logic signed [VAL_W-1:0] rd_b_reg;

    state_t state_reg;
    state_t state_next;
    logic [CW-1:0] i_reg;
    logic [CW-1:0] i_next;
    logic [CW-1:0] j_reg;
    logic [CW-1:0] j_next;
    logic [CW-1:0] m_reg;
    logic [CW-1:0] m_next;
    logic [CW-1:0] n_reg;
    logic [CW-1:0] n_next;
    logic ovf_reg;
    logic ovf_next;
    logic pend_valid_reg;
    logic pend_valid_next;
    logic signed [VAL_W-1:0] pend_value_reg;
    logic signed [VAL_W-1:0] pend_value_next;
    logic signed [VAL_W-1:0] prev_a_reg;
    logic signed [VAL_W-1:0] prev_a_next;
    logic signed [VAL_W-1:0] prev_b_reg;
    logic signed [VAL_W-1:0] prev_b_next;

    logic wr_a;
    logic wr_b;
    logic has_a;
    logic has_b;
    logic dup_a;
    logic dup_b;
    logic adv_a;
    logic adv_b;
    logic emit;
    logic signed [VAL_W-1:0] emit_value;
    logic stall;

    assign has_a = (i_reg < m_reg);
    assign has_b = (j_reg < n_reg);
    assign dup_a = (i_reg != '0) && (prev_a_reg == rd_a_reg);
    assign dup_b = (j_reg != '0) && (prev_b_reg == rd_b_reg);

    // One step of the two-pointer walk. Repeats within a list are skipped
    // first; a value at the head of both lists is emitted once.
    always_comb
    begin
        adv_a = 1'b0;
        adv_b = 1'b0;
        emit = 1'b0;
        emit_value = rd_a_reg;
        priority if (has_a && dup_a)
        begin
            adv_a = 1'b1;
        end
        else if (has_b && dup_b)
        begin
            adv_b = 1'b1;
        end
        else if (has_a && has_b)
        begin
            emit = 1'b1;
            if (rd_a_reg < rd_b_reg)
            begin
                adv_a = 1'b1;
            end
            else if (rd_a_reg > rd_b_reg)
            begin
                adv_b = 1'b1;
                emit_value = rd_b_reg;
            end
            else
            begin
                adv_a = 1'b1;
                adv_b = 1'b1;
            end
        end
        else if (has_a)
        begin
            emit = 1'b1;
            adv_a = 1'b1;
        end
        else if (has_b)
        begin
            emit = 1'b1;
            adv_b = 1'b1;
            emit_value = rd_b_reg;
        end
    end

    // A new result can only displace the held one once the queue has room.
    assign stall = emit && pend_valid_reg && out_full;

    always_comb
    begin
        state_next = state_reg;
        i_next = i_reg;
        j_next = j_reg;
        m_next = m_reg;
        n_next = n_reg;
        ovf_next = ovf_reg;
        pend_valid_next = pend_valid_reg;
        pend_value_next = pend_value_reg;
        prev_a_next = prev_a_reg;
        prev_b_next = prev_b_reg;
        q_pop = 1'b0;
        wr_a = 1'b0;
        wr_b = 1'b0;
        out_push = 1'b0;
        out_data.union_value = pend_value_reg;
        out_data.last = 1'b0;
        out_data.empty_res = 1'b0;
        out_data.overflowed = ovf_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    unique case (q_data.op)
                        CMD_LOAD_A:
                        begin
                            wr_a = 1'b1;
                        end
                        CMD_LOAD_B:
                        begin
                            wr_b = 1'b1;
                        end
                        CMD_MERGE:
                        begin
                            m_next = q_data.cnt_a[CW-1:0];
                            n_next = q_data.cnt_b[CW-1:0];
                            ovf_next = q_data.ovf;
                            i_next = '0;
                            j_next = '0;
                            pend_valid_next = 1'b0;
                            if (q_data.cnt_a == '0 && q_data.cnt_b == '0)
                            begin
                                state_next = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = ST_FETCH;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_EMPTY:
            begin
                out_data.union_value = '0;
                out_data.last = 1'b1;
                out_data.empty_res = 1'b1;
                if (!out_full)
                begin
                    out_push = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (!stall)
                begin
                    if (emit)
                    begin
                        out_push = pend_valid_reg;
                        pend_valid_next = 1'b1;
                        pend_value_next = emit_value;
                    end
                    if (adv_a)
                    begin
                        i_next = i_reg + CW'(1);
                        prev_a_next = rd_a_reg;
                    end
                    if (adv_b)
                    begin
                        j_next = j_reg + CW'(1);
                        prev_b_next = rd_b_reg;
                    end
                    if (i_next >= m_reg && j_next >= n_reg)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FLUSH:
            begin
                out_data.last = 1'b1;
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (!out_full)
                begin
                    out_push = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_a)
        begin
            mem_a[q_data.addr[AW-1:0]] <= q_data.value;
        end
        if (wr_b)
        begin
            mem_b[q_data.addr[AW-1:0]] <= q_data.value;
        end
        if (state_reg == ST_FETCH)
        begin
            rd_a_reg <= mem_a[i_reg[AW-1:0]];
            rd_b_reg <= mem_b[j_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg <= '0;
            j_reg <= '0;
            m_reg <= '0;
            n_reg <= '0;
            ovf_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_value_reg <= '0;
            prev_a_reg <= '0;
            prev_b_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg <= i_next;
            j_reg <= j_next;
            m_reg <= m_next;
            n_reg <= n_next;
            ovf_reg <= ovf_next;
            pend_valid_reg <= pend_valid_next;
            pend_value_reg <= pend_value_next;
            prev_a_reg <= prev_a_next;
            prev_b_reg <= prev_b_next;
        end
    end

`ifndef SYNTH
    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> !out_full)
        else $error("result pushed into a full queue");

    a_pointers_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVAL) |-> (i_reg <= m_reg && j_reg <= n_reg))
        else $error("merge pointer ran past its list");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_push && out_data.last) |=> (state_reg == ST_IDLE && !pend_valid_reg))
        else $error("run continued after its final result");
`endif

endmodule

// ----- rtl/sorted_list_union_merge.sv -----
// Builds the distinct ascending union of two sorted lists of signed 32-bit
// values. Action 0 appends to list A, action 1 to list B, action 2 merges
// and returns the union one value per result, the final one marked with
// last; loads beyond DEPTH are dropped and reported through overflowed on
// every result of the next run, and a run over two empty lists returns one
// result with empty_res set. The front end decodes each transaction and
// keeps the list counts, so it takes one input per cycle while the command
// queue has room; loads pass through the command queue and reach the list
// memories when the back end is idle. Each step of a merge's walk is a
// registered read of both list memories, then the compare, and a step visits
// one entry, or one entry of each list where both heads hold the same value.
// Results wait in a two-entry queue and in one held register, since the
// last result of a run is known only when both lists are exhausted.
module sorted_list_union_merge
    import slum_pkg::*;
#(
    parameter int DEPTH = LIST_DEPTH
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    output logic    full,
    input  item_t   item,
    output logic    empty,
    input  logic    pop,
    output result_t result
);

    logic    cmd_push;
    logic    cmd_full;
    cmd_t    cmd_wdata;
    logic    cmd_empty;
    logic    cmd_pop;
    cmd_t    cmd_rdata;
    logic    res_push;
    logic    res_full;
    result_t res_wdata;

    slum_front #(
        .DEPTH(DEPTH)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .item(item),
        .cmd_push(cmd_push),
        .cmd_full(cmd_full),
        .cmd_data(cmd_wdata)
    );

    slum_fifo #(
        .T(cmd_t),
        .DEPTH_Q(CMDQ_DEPTH)
    ) u_cmdq (
        .clk(clk),
        .rst_n(rst_n),
        .push(cmd_push),
        .full(cmd_full),
        .wdata(cmd_wdata),
        .pop(cmd_pop),
        .empty(cmd_empty),
        .rdata(cmd_rdata)
    );

    slum_back #(
        .DEPTH(DEPTH)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .q_empty(cmd_empty),
        .q_data(cmd_rdata),
        .q_pop(cmd_pop),
        .out_push(res_push),
        .out_full(res_full),
        .out_data(res_wdata)
    );

    slum_fifo #(
        .T(result_t),
        .DEPTH_Q(RESQ_DEPTH)
    ) u_resq (
        .clk(clk),
        .rst_n(rst_n),
        .push(res_push),
        .full(res_full),
        .wdata(res_wdata),
        .pop(pop),
        .empty(empty),
        .rdata(result)
    );

endmodule

// ----- tb/sv/sorted_list_union_merge_tb.sv -----
`timescale 1ns / 100ps

module sorted_list_union_merge_tb;
    import slum_pkg::*;

    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

    localparam int STYLE_NARROW = 0;
    localparam int STYLE_WIDE = 1;
    localparam int STYLE_UNSORTED = 2;

    localparam int RANDOM_ITEMS = 110;

    class union_scoreboard;
        logic signed [31:0] list_a [LIST_DEPTH];
        logic signed [31:0] list_b [LIST_DEPTH];
        int count_a;
        int count_b;
        bit overflow;
        result_t union_q[$];
        int errors;

        function void add_value(logic signed [31:0] v, bit no_lists);
            result_t r;
            r.union_value = v;
            r.last = 1'b0;
            r.empty_res = no_lists;
            r.overflowed = overflow;
            union_q.push_back(r);
        endfunction

        // Two-pointer walk over both lists, skipping repeats within a list.
        function void merge_union();
            int i;
            int j;
            result_t r;
            i = 0;
            j = 0;
            if (count_a == 0 && count_b == 0)
            begin
                add_value('0, 1'b1);
            end
            else
            begin
                while (i < count_a && j < count_b)
                begin
                    if (i > 0 && list_a[i-1] == list_a[i])
                        i++;
                    else if (j > 0 && list_b[j-1] == list_b[j])
                        j++;
                    else if (list_a[i] < list_b[j])
                    begin
                        add_value(list_a[i], 1'b0);
                        i++;
                    end
                    else if (list_a[i] > list_b[j])
                    begin
                        add_value(list_b[j], 1'b0);
                        j++;
                    end
                    else
                    begin
                        add_value(list_a[i], 1'b0);
                        i++;
                        j++;
                    end
                end
                while (i < count_a)
                begin
                    if (i == 0 || list_a[i] != list_a[i-1])
                        add_value(list_a[i], 1'b0);
                    i++;
                end
                while (j < count_b)
                begin
                    if (j == 0 || list_b[j] != list_b[j-1])
                        add_value(list_b[j], 1'b0);
                    j++;
                end
            end
            r = union_q.pop_back();
            r.last = 1'b1;
            union_q.push_back(r);
            count_a = 0;
            count_b = 0;
            overflow = 1'b0;
        endfunction

        function void note_item(item_t it);
            case (it.action)
                ACT_LOAD_A:
                begin
                    if (count_a < LIST_DEPTH)
                    begin
                        list_a[count_a] = it.value;
                        count_a++;
                    end
                    else
                        overflow = 1'b1;
                end
                ACT_LOAD_B:
                begin
                    if (count_b < LIST_DEPTH)
                    begin
                        list_b[count_b] = it.value;
                        count_b++;
                    end
                    else
                        overflow = 1'b1;
                end
                ACT_MERGE: merge_union();
                default: ;
            endcase
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (union_q.size() == 0)
            begin
                $error("unexpected result: union_value %0d last %0b",
                       got.union_value, got.last);
                errors++;
                return;
            end
            want = union_q.pop_front();
            // The value carries no meaning on the result of a run over two empty lists.
            if (!want.empty_res && got.union_value !== want.union_value)
            begin
                $error("union_value: expected %0d, got %0d", want.union_value, got.union_value);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0b, got %0b", want.last, got.last);
                errors++;
            end
            if (got.empty_res !== want.empty_res)
            begin
                $error("empty_res: expected %0b, got %0b", want.empty_res, got.empty_res);
                errors++;
            end
            if (got.overflowed !== want.overflowed)
            begin
                $error("overflowed: expected %0b, got %0b", want.overflowed, got.overflowed);
                errors++;
            end
        endfunction

        function int pending();
            return union_q.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    item_t item = '0;
    logic empty;
    logic pop = 1'b0;
    result_t result;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int items_sent = 0;

    union_scoreboard sb;

    sorted_list_union_merge dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Push is left high after a transaction so that back-to-back items need no gap.
    task send_item(input logic [1:0] act, input logic signed [31:0] v);
        item_t it;
        it.action = act;
        it.value = v;
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_item(it);
        items_sent++;
    endtask

    function automatic logic signed [31:0] next_value(int style, inout longint cur);
        if (style == STYLE_UNSORTED)
            return $urandom;
        if (style == STYLE_WIDE)
            cur += longint'($urandom_range(32'h1000_0000));
        else
            cur += longint'($urandom_range(2));
        if (cur > longint'(VAL_MAX))
            cur = longint'(VAL_MAX);
        return cur[31:0];
    endfunction

    // Loads both lists with their loads interleaved at random, then merges.
    task run_lists(input int len_a, input int len_b, input int style);
        longint cur_a;
        longint cur_b;
        int na;
        int nb;
        bit to_a;
        if (style == STYLE_NARROW)
        begin
            // A shared start gives plenty of repeats and common values.
            cur_a = longint'($signed($urandom));
            cur_b = cur_a;
        end
        else
        begin
            cur_a = ($urandom_range(3) == 0) ? longint'(VAL_MIN)
                                             : longint'(VAL_MIN) + $urandom_range(32'h7FFF_FFFF);
            cur_b = ($urandom_range(3) == 0) ? longint'(VAL_MIN)
                                             : longint'(VAL_MIN) + $urandom_range(32'h7FFF_FFFF);
        end
        na = len_a;
        nb = len_b;
        while (na > 0 || nb > 0)
        begin
            if ($urandom_range(19) == 0)
                send_item(ACT_NONE, $urandom);
            to_a = (nb == 0) || (na > 0 && $urandom_range(1) == 1);
            if (to_a)
            begin
                send_item(ACT_LOAD_A, next_value(style, cur_a));
                na--;
            end
            else
            begin
                send_item(ACT_LOAD_B, next_value(style, cur_b));
                nb--;
            end
        end
        send_item(ACT_MERGE, $urandom);
    endtask

    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                sb.check_result(result);
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        int start_count;
        int phase;
        int roll;
        int style;
        int len_a;
        int len_b;

        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed transactions: empty run, extremes, repeats, common values,
        // an ignored action and an unsorted list.
        send_item(ACT_MERGE, 32'sd0);
        send_item(ACT_LOAD_A, VAL_MIN);
        send_item(ACT_LOAD_A, -32'sd7);
        send_item(ACT_LOAD_A, -32'sd7);
        send_item(ACT_LOAD_A, VAL_MAX);
        send_item(ACT_NONE, 32'sd12345);
        send_item(ACT_LOAD_B, -32'sd7);
        send_item(ACT_LOAD_B, 32'sd0);
        send_item(ACT_LOAD_B, 32'sd0);
        send_item(ACT_LOAD_B, VAL_MAX);
        send_item(ACT_MERGE, VAL_MAX);
        send_item(ACT_LOAD_B, -32'sd1);
        send_item(ACT_MERGE, VAL_MIN);
        send_item(ACT_LOAD_A, 32'sd0);
        send_item(ACT_LOAD_A, -32'sd1);
        send_item(ACT_LOAD_B, -32'sd1);
        send_item(ACT_MERGE, 32'sd0);
        send_item(ACT_NONE, VAL_MIN);
        send_item(ACT_MERGE, 32'sd0);

        // Overflow of both lists, then two full lists for the longest run.
        run_lists(17 + $urandom_range(1), 17, STYLE_NARROW);
        run_lists(LIST_DEPTH, LIST_DEPTH, STYLE_WIDE);

        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS)
        begin
            phase = (items_sent - start_count) / (RANDOM_ITEMS / 4);
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 80;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 80;
                end
                default:
                begin
                    send_idle_pct = 20;
                    recv_stall_pct = 20;
                end
            endcase
            roll = $urandom_range(99);
            style = (roll < 50) ? STYLE_NARROW : (roll < 85) ? STYLE_WIDE : STYLE_UNSORTED;
            if ($urandom_range(11) == 0)
            begin
                len_a = $urandom_range(17, 18);
                len_b = $urandom_range(5);
            end
            else if ($urandom_range(7) == 0)
            begin
                len_a = $urandom_range(LIST_DEPTH);
                len_b = $urandom_range(LIST_DEPTH);
            end
            else
            begin
                len_a = $urandom_range(5);
                len_b = $urandom_range(5);
            end
            run_lists(len_a, len_b, style);
        end
        push <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
